// ----- hw/rtl/mscc_pkg.sv -----
// shared constants, types and codes for the max-sat clause counter
// no dependencies; used by mscc_row_eval, max_sat_clause_counter and mscc_checker
package mscc_pkg;

   localparam int MAX_CLAUSES = 256;
   localparam int MAX_LITS    = 8;
   localparam int MAX_VARS    = 64;

   localparam int LIT_W      = 8;
   localparam int ROW_ADDR_W = $clog2(MAX_CLAUSES);
   localparam int SLOT_W     = 3;
   localparam int CLAUSE_W   = 8;
   localparam int VAR_IDX_W  = $clog2(MAX_VARS);
   localparam int ASSIGN_W   = 64;
   localparam int CNT_W      = 9;
   localparam int NTRUE_W    = $clog2(MAX_LITS + 1);
   localparam int ROW_W      = MAX_LITS * LIT_W;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 9;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;

   localparam logic [NTRUE_W-1:0] NAE_ALL_TRUE = NTRUE_W'(3);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVAL  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LIMIT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_NAE_MODE  = CSR_IDX_W'(1);

   typedef logic [MAX_LITS-1:0][LIT_W-1:0] row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/mscc_ram.sv -----
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module mscc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mscc_row_eval.sv -----
// evaluates one clause row against an assignment under the mode rule
// depends on mscc_pkg
module mscc_row_eval (
   input  mscc_pkg::row_type                 row,
   input  logic [mscc_pkg::ASSIGN_W-1:0]     assignment,
   input  logic                              nae_mode,
   output logic                              clause_hit
);

   logic [mscc_pkg::MAX_LITS-1:0] lit_true;
   logic [mscc_pkg::NTRUE_W-1:0]  ntrue;

   always_comb begin
      logic [mscc_pkg::LIT_W-1:0] raw;
      logic [mscc_pkg::LIT_W-1:0] mag;
      logic [mscc_pkg::LIT_W-1:0] mag_m1;
      logic                       val;
      for (int i = 0; i < mscc_pkg::MAX_LITS; i++) begin
         raw    = row[i];
         mag    = raw[mscc_pkg::LIT_W-1] ? (~raw + mscc_pkg::LIT_W'(1)) : raw;
         mag_m1 = mag - mscc_pkg::LIT_W'(1);
         val    = assignment[mag_m1[mscc_pkg::VAR_IDX_W-1:0]];
         if (raw == '0 || ({1'b0, mag} > (mscc_pkg::LIT_W + 1)'(mscc_pkg::MAX_VARS))) begin
            lit_true[i] = 1'b0;
         end else begin
            lit_true[i] = raw[mscc_pkg::LIT_W-1] ? ~val : val;
         end
      end
   end

   always_comb begin
      ntrue = '0;
      for (int i = 0; i < mscc_pkg::MAX_LITS; i++) begin
         ntrue = ntrue + mscc_pkg::NTRUE_W'(lit_true[i]);
      end
   end

   assign clause_hit = nae_mode ? (ntrue != '0 && ntrue != mscc_pkg::NAE_ALL_TRUE)
                                : (ntrue != '0);

endmodule

// ----- hw/rtl/max_sat_clause_counter.sv -----
// max-sat clause counter top level: clause table in per-slot rams, row walker
// depends on mscc_pkg, mscc_ram, mscc_row_eval
//
// req channel: tuser = kind (0 write one literal slot, 1 evaluate).
//   a write stores literal at (clause_index, slot_index) and gives no result.
//   an evaluate walks the first min(row limit, 256) rows, one row per cycle
//   from the table rams, and gives one rsp transfer.
// rsp channel: satisfied_count and all_satisfied, held in an output register.
// csr channel: index 0 row limit, index 1 nae_mode; always ready.
// sequence: a write is stored when it is taken; an evaluate steps through the
//   eval state, reading the table rows in order on the shared read address,
//   then the done state, which loads the output register.
//   writes are taken back to back; one evaluate is in flight at a time.
// reset: a clearing pass zeroes every table row, one row per cycle, with
//   req_tready low; the csr channel is served during it.
// stall: while a result waits in the output register, writes and a new
//   evaluate are still taken; the next result waits in its last step until
//   the register is free.
module max_sat_clause_counter (
   input  logic                              clock,
   input  logic                              reset,
   // tdata: clause_index[7:0], slot_index[10:8], literal[18:11], assignment[82:19]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mscc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: kind[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: satisfied_count[8:0], all_satisfied[9]
   output logic [mscc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mscc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mscc_pkg::CSR_DATA_W-1:0]   csr_data
);

   mscc_pkg::state_type state_ff, state_in;

   logic [mscc_pkg::CLAUSE_W-1:0]   req_clause;
   logic [mscc_pkg::SLOT_W-1:0]     req_slot;
   logic [mscc_pkg::LIT_W-1:0]      req_literal;
   logic [mscc_pkg::ASSIGN_W-1:0]   req_assign;
   logic                            req_xfer;

   logic [mscc_pkg::CNT_W-1:0]      row_limit_ff;
   logic                            nae_mode_ff;

   logic [mscc_pkg::ROW_ADDR_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic [mscc_pkg::CNT_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [mscc_pkg::CNT_W-1:0]      used_ff, used_in;
   logic [mscc_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [mscc_pkg::ASSIGN_W-1:0]   assign_ff, assign_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mscc_pkg::CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                            rsp_all_ff, rsp_all_in;

   logic                            issue;
   logic                            rsp_free;
   logic                            clause_hit;
   mscc_pkg::row_type               row;
   logic [mscc_pkg::MAX_LITS-1:0]   lane_wr_en;
   logic [mscc_pkg::ROW_ADDR_W-1:0] wr_addr;
   logic [mscc_pkg::LIT_W-1:0]      wr_data;

   assign req_clause  = req_tdata[7:0];
   assign req_slot    = req_tdata[10:8];
   assign req_literal = req_tdata[18:11];
   assign req_assign  = req_tdata[82:19];

   assign req_tready = (state_ff == mscc_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff <= '0;
         nae_mode_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == mscc_pkg::CSR_ROW_LIMIT) begin
            row_limit_ff <= csr_data;
         end else if (csr_index == mscc_pkg::CSR_NAE_MODE) begin
            nae_mode_ff <= csr_data[0];
         end
      end
   end

   // table write port: clearing pass or a write transfer
   assign wr_addr = (state_ff == mscc_pkg::ST_CLEAR) ? clr_ptr_ff
                                                     : req_clause[mscc_pkg::ROW_ADDR_W-1:0];
   assign wr_data = (state_ff == mscc_pkg::ST_CLEAR) ? '0 : req_literal;

   always_comb begin
      for (int i = 0; i < mscc_pkg::MAX_LITS; i++) begin
         lane_wr_en[i] = (state_ff == mscc_pkg::ST_CLEAR) ||
                         (req_xfer && req_tuser == mscc_pkg::KIND_WRITE &&
                          {{(32 - mscc_pkg::SLOT_W){1'b0}}, req_slot} == 32'(i) &&
                          {{(32 - mscc_pkg::CLAUSE_W){1'b0}}, req_clause}
                             < 32'(mscc_pkg::MAX_CLAUSES));
      end
   end

   for (genvar g = 0; g < mscc_pkg::MAX_LITS; g++) begin : g_lane
      mscc_ram #(
         .WIDTH (mscc_pkg::LIT_W),
         .DEPTH (mscc_pkg::MAX_CLAUSES)
      ) u_ram (
         .clock   (clock),
         .wr_en   (lane_wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_addr (rd_ptr_ff[mscc_pkg::ROW_ADDR_W-1:0]),
         .rd_data (row[g])
      );
   end

   mscc_row_eval u_row_eval (
      .row        (row),
      .assignment (assign_ff),
      .nae_mode   (nae_mode_ff),
      .clause_hit (clause_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mscc_pkg::ST_CLEAR;
      end else begin
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         rd_ptr_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ptr_ff   <= clr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      used_ff      <= used_in;
      count_ff     <= count_in;
      assign_ff    <= assign_in;
      rsp_count_ff <= rsp_count_in;
      rsp_all_ff   <= rsp_all_in;
   end

   assign issue = (state_ff == mscc_pkg::ST_EVAL) && (rd_ptr_ff != used_ff);

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_vld_in    = issue;
      used_in      = used_ff;
      count_in     = count_ff;
      assign_in    = assign_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      rsp_all_in   = rsp_all_ff;

      if (rd_vld_ff && clause_hit) begin
         count_in = count_ff + mscc_pkg::CNT_W'(1);
      end

      unique case (state_ff)
         mscc_pkg::ST_CLEAR: begin
            clr_ptr_in = clr_ptr_ff + mscc_pkg::ROW_ADDR_W'(1);
            if (clr_ptr_ff == mscc_pkg::ROW_ADDR_W'(mscc_pkg::MAX_CLAUSES - 1)) begin
               state_in = mscc_pkg::ST_IDLE;
            end
         end
         mscc_pkg::ST_IDLE: begin
            if (req_xfer && req_tuser == mscc_pkg::KIND_EVAL) begin
               assign_in = req_assign;
               count_in  = '0;
               rd_ptr_in = '0;
               if (row_limit_ff > mscc_pkg::CNT_W'(mscc_pkg::MAX_CLAUSES)) begin
                  used_in = mscc_pkg::CNT_W'(mscc_pkg::MAX_CLAUSES);
               end else begin
                  used_in = row_limit_ff;
               end
               state_in = mscc_pkg::ST_EVAL;
            end
         end
         mscc_pkg::ST_EVAL: begin
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + mscc_pkg::CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = mscc_pkg::ST_DONE;
            end
         end
         mscc_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               rsp_all_in   = (count_ff == used_ff);
               state_in     = mscc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mscc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(mscc_pkg::RSP_DATA_W - mscc_pkg::CNT_W - 1){1'b0}},
                        rsp_all_ff, rsp_count_ff};

endmodule

// ----- hw/rtl/mscc_checker.sv -----
// port-level checks for max_sat_clause_counter, attached by bind
// depends on mscc_pkg and the top level's ports
module mscc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mscc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // clearing pass blocks requests and no result is pending after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request or result open right after reset");

   // an evaluate transfer occupies the block on the next cycle
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == mscc_pkg::KIND_EVAL) |=> !req_tready)
      else $error("request taken while an evaluate is in flight");

   // a write transfer never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == mscc_pkg::KIND_WRITE)
         |=> !$rose(rsp_tvalid))
      else $error("result raised by a write transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind max_sat_clause_counter mscc_checker u_mscc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
